// ----- rtl/core/mhs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_pkg
// Shared types and constants for the mask history statistics ring.
// ----------------------------------------------------------------------------
package mhs_pkg;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_RANGE = 2'd1;
	localparam logic [1:0] OP_STATS = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] KIND_SUM   = 2'd0;
	localparam logic [1:0] KIND_NONE  = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;
	localparam logic [1:0] KIND_STATS = 2'd3;

	localparam int IN_DATA_W  = 184;
	localparam int OUT_DATA_W = 176;
	localparam int PCT_W      = 23;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic rq_init;
		logic rec_rd;
		logic rq_eval;
		logic rq_acc;
		logic ch_rd;
		logic ch_wr;
		logic rec_next;
		logic out_init;
		logic out_rd;
		logic out_ld;
		logic ld_nf;
		logic ld_err;
		logic ld_st;
		logic sq_init;
		logic sq_eval;
		logic sq_acc;
		logic div_init;
		logic div_prep;
		logic div_step;
	} mhs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fill_zero;
		logic win_zero;
		logic overlap;
		logic mismatch;
		logic found;
		logic cc_zero;
		logic j_last;
		logic i_last;
		logic out_free;
		logic div_done;
	} mhs_sts_t;

endpackage

// ----- rtl/core/mhs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/mhs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_ctrl
// Sequencer for adds, range walks, stats walks and the result requests.
// ----------------------------------------------------------------------------
module mhs_ctrl
	import mhs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] s_tuser,
	output logic       s_tready,
	input  mhs_sts_t   sts,
	output mhs_cmd_t   cmd
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_RQ_INIT = 5'd1;
	localparam logic [4:0] ST_RQ_RD   = 5'd2;
	localparam logic [4:0] ST_RQ_EVAL = 5'd3;
	localparam logic [4:0] ST_RQ_ACC  = 5'd4;
	localparam logic [4:0] ST_RQ_CRD  = 5'd5;
	localparam logic [4:0] ST_RQ_CWR  = 5'd6;
	localparam logic [4:0] ST_RQ_END  = 5'd7;
	localparam logic [4:0] ST_OUT_RD  = 5'd8;
	localparam logic [4:0] ST_OUT_LD  = 5'd9;
	localparam logic [4:0] ST_RES_NF  = 5'd10;
	localparam logic [4:0] ST_RES_ERR = 5'd11;
	localparam logic [4:0] ST_SQ_INIT = 5'd12;
	localparam logic [4:0] ST_SQ_RD   = 5'd13;
	localparam logic [4:0] ST_SQ_EVAL = 5'd14;
	localparam logic [4:0] ST_SQ_ACC  = 5'd15;
	localparam logic [4:0] ST_SQ_DINI = 5'd16;
	localparam logic [4:0] ST_SQ_PREP = 5'd17;
	localparam logic [4:0] ST_SQ_DIV  = 5'd18;
	localparam logic [4:0] ST_RES_ST  = 5'd19;

	logic [4:0] state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.take = s_tvalid;
				if (s_tvalid && s_tuser == OP_RANGE)
					state_d = ST_RQ_INIT;
				else if (s_tvalid && s_tuser == OP_STATS)
					state_d = ST_SQ_INIT;
			end
			ST_RQ_INIT: begin
				cmd.rq_init = 1'b1;
				state_d = sts.fill_zero ? ST_RES_NF : ST_RQ_RD;
			end
			ST_RQ_RD: begin
				cmd.rec_rd = 1'b1;
				state_d = ST_RQ_EVAL;
			end
			ST_RQ_EVAL: begin
				cmd.rq_eval = 1'b1;
				if (!sts.overlap) begin
					cmd.rec_next = 1'b1;
					state_d = sts.i_last ? ST_RQ_END : ST_RQ_RD;
				end else if (sts.mismatch) begin
					state_d = ST_RES_ERR;
				end else begin
					state_d = ST_RQ_ACC;
				end
			end
			ST_RQ_ACC: begin
				cmd.rq_acc = 1'b1;
				if (sts.cc_zero) begin
					cmd.rec_next = 1'b1;
					state_d = sts.i_last ? ST_RQ_END : ST_RQ_RD;
				end else begin
					state_d = ST_RQ_CRD;
				end
			end
			ST_RQ_CRD: begin
				cmd.ch_rd = 1'b1;
				state_d = ST_RQ_CWR;
			end
			ST_RQ_CWR: begin
				cmd.ch_wr = 1'b1;
				if (sts.j_last) begin
					cmd.rec_next = 1'b1;
					state_d = sts.i_last ? ST_RQ_END : ST_RQ_RD;
				end else begin
					state_d = ST_RQ_CRD;
				end
			end
			ST_RQ_END: begin
				cmd.out_init = 1'b1;
				state_d = sts.found ? ST_OUT_RD : ST_RES_NF;
			end
			ST_OUT_RD: begin
				cmd.out_rd = 1'b1;
				state_d = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = (sts.cc_zero || sts.j_last) ? ST_IDLE : ST_OUT_RD;
				end
			end
			ST_RES_NF: begin
				if (sts.out_free) begin
					cmd.ld_nf = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RES_ERR: begin
				if (sts.out_free) begin
					cmd.ld_err = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SQ_INIT: begin
				cmd.sq_init = 1'b1;
				state_d = sts.win_zero ? ST_SQ_DINI : ST_SQ_RD;
			end
			ST_SQ_RD: begin
				cmd.rec_rd = 1'b1;
				state_d = ST_SQ_EVAL;
			end
			ST_SQ_EVAL: begin
				cmd.sq_eval = 1'b1;
				state_d = ST_SQ_ACC;
			end
			ST_SQ_ACC: begin
				cmd.sq_acc = 1'b1;
				state_d = sts.i_last ? ST_SQ_DINI : ST_SQ_RD;
			end
			ST_SQ_DINI: begin
				cmd.div_init = 1'b1;
				state_d = ST_SQ_PREP;
			end
			ST_SQ_PREP: begin
				cmd.div_prep = 1'b1;
				state_d = ST_SQ_DIV;
			end
			ST_SQ_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done)
					state_d = ST_RES_ST;
			end
			ST_RES_ST: begin
				if (sts.out_free) begin
					cmd.ld_st = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- rtl/core/mhs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_dp
// Record ring, channel store, accumulators, divider and output register.
// ----------------------------------------------------------------------------
module mhs_dp
	import mhs_pkg::*;
#(
	parameter int HISTORY   = 16,
	parameter int MAX_CHANS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast,
	input  mhs_cmd_t              cmd,
	output mhs_sts_t              sts
);

	localparam int SLW  = HISTORY > 1 ? $clog2(HISTORY) : 1;
	localparam int FLW  = $clog2(HISTORY + 1);
	localparam int CHW  = MAX_CHANS > 1 ? $clog2(MAX_CHANS) : 1;
	localparam int CAW  = $clog2((HISTORY + 1) * MAX_CHANS);
	localparam int RW   = 93 + FLW + MAX_CHANS;
	localparam int SUMW = 22 + FLW;
	localparam int NW   = SUMW + 25;

	// input fields
	logic [47:0] in_pos, in_end;
	logic [15:0] in_len, in_cu, in_win;
	logic [6:0]  in_cc;
	logic [21:0] in_unm;
	logic [5:0]  in_ci;
	assign in_pos = s_tdata[47:0];
	assign in_end = s_tdata[95:48];
	assign in_len = s_tdata[111:96];
	assign in_cc  = s_tdata[118:112];
	assign in_unm = s_tdata[140:119];
	assign in_ci  = s_tdata[146:141];
	assign in_cu  = s_tdata[162:147];
	assign in_win = s_tdata[178:163];

	logic [SLW-1:0] wslot_q, rslot_q;
	logic [FLW-1:0] fill_q, i_q, lim_q, pslot_q;
	logic [MAX_CHANS-1:0] mask_q, mask_set;
	logic [47:0] lo_q, hi_q, first_pos_q;
	logic [15:0] win_q;
	logic [6:0]  cc_q, j_q;
	logic        found_q, first_rec_q;
	logic [19:0] tl_q;
	logic [25:0] samp_q, unm_q;
	logic [22:0] prod_q;
	logic [SUMW-1:0] s_q, u_q, d_q;
	logic            dz_q;
	logic [SUMW:0]   dv_q;
	logic [SUMW+1:0] rem_q;
	logic [22:0]     nlo_q, quo_q;
	logic [4:0]      step_q;

	// ring write side
	logic add_word, ci_ok, commit;
	logic [6:0] cc_clamp;
	assign add_word = cmd.take && (s_tuser == OP_ADD);
	assign ci_ok    = (7'(in_ci) < 7'(MAX_CHANS));
	assign commit   = add_word && s_tlast;
	assign mask_set = ci_ok ? (MAX_CHANS'(1) << in_ci[CHW-1:0]) : '0;
	assign cc_clamp = (in_cc > 7'(MAX_CHANS)) ? 7'(MAX_CHANS) : in_cc;

	// channel store has one spare slot for staging; each record keeps its slot
	logic [RW-1:0] rec_wdata, rec_rdata;
	assign rec_wdata = {mask_q | mask_set, pslot_q, in_unm, cc_clamp, in_len, in_pos};

	mhs_ram #(.WIDTH(RW), .DEPTH(HISTORY)) u_rec_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (wslot_q),
		.wdata (rec_wdata),
		.re    (cmd.rec_rd),
		.raddr (rslot_q),
		.rdata (rec_rdata)
	);

	logic [47:0] r_pos;
	logic [15:0] r_len;
	logic [6:0]  r_chans;
	logic [21:0] r_unm;
	logic [FLW-1:0] r_cslot;
	logic [MAX_CHANS-1:0] r_mask;
	assign r_pos   = rec_rdata[47:0];
	assign r_len   = rec_rdata[63:48];
	assign r_chans = rec_rdata[70:64];
	assign r_unm   = rec_rdata[92:71];
	assign r_cslot = rec_rdata[92+FLW:93];
	assign r_mask  = rec_rdata[RW-1:93+FLW];

	logic [CAW-1:0] ch_waddr, ch_raddr;
	logic [15:0]    ch_rdata;
	assign ch_waddr = CAW'(pslot_q) * CAW'(MAX_CHANS) + CAW'(in_ci[CHW-1:0]);
	assign ch_raddr = CAW'(r_cslot) * CAW'(MAX_CHANS) + CAW'(j_q[CHW-1:0]);

	mhs_ram #(.WIDTH(16), .DEPTH((HISTORY + 1) * MAX_CHANS)) u_chan_ram (
		.clk   (clk),
		.we    (add_word && ci_ok),
		.waddr (ch_waddr),
		.wdata (in_cu),
		.re    (cmd.ch_rd),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	// per-channel accumulators
	logic [19:0] acc_rdata, acc_wdata, ch_val;
	logic [20:0] acc_sum;
	assign ch_val    = r_mask[j_q[CHW-1:0]] ? 20'(ch_rdata) : 20'd0;
	assign acc_sum   = 21'(acc_rdata) + 21'(ch_val);
	assign acc_wdata = first_rec_q ? ch_val : (acc_sum[20] ? 20'hFFFFF : acc_sum[19:0]);

	mhs_ram #(.WIDTH(20), .DEPTH(MAX_CHANS)) u_acc_ram (
		.clk   (clk),
		.we    (cmd.ch_wr),
		.waddr (j_q[CHW-1:0]),
		.wdata (acc_wdata),
		.re    (cmd.ch_rd || cmd.out_rd),
		.raddr (j_q[CHW-1:0]),
		.rdata (acc_rdata)
	);

	// status
	logic        overlap;
	logic [15:0] win_cl;
	logic [FLW-1:0] win_lim;
	assign overlap = ((49'(r_pos) + 49'(r_len)) > 49'(lo_q)) && (r_pos < hi_q);
	assign win_cl  = (win_q > 16'(HISTORY)) ? 16'(HISTORY) : win_q;
	assign win_lim = (win_cl < 16'(fill_q)) ? FLW'(win_cl) : fill_q;

	assign sts.fill_zero = (fill_q == '0);
	assign sts.win_zero  = (win_lim == '0);
	assign sts.overlap   = overlap;
	assign sts.mismatch  = found_q && (r_chans != cc_q);
	assign sts.found     = found_q;
	assign sts.cc_zero   = (cc_q == 7'd0);
	assign sts.j_last    = ((j_q + 7'd1) == cc_q);
	assign sts.i_last    = ((i_q + FLW'(1)) == lim_q);
	assign sts.out_free  = !m_tvalid || m_tready;
	assign sts.div_done  = (step_q == 5'd22);

	// saturating sums
	logic [20:0] tl_sum;
	logic [26:0] samp_sum, unm_sum;
	assign tl_sum   = 21'(tl_q) + 21'(r_len);
	assign samp_sum = 27'(samp_q) + 27'(prod_q);
	assign unm_sum  = 27'(unm_q) + 27'(r_unm);

	// divider: pct = floor((13107200*d + s) / 2s), 13107200 = 200 << 16
	logic [NW-1:0]   num;
	logic [SUMW+1:0] dtry;
	logic            dge;
	assign num  = ((NW'(d_q) << 23) + (NW'(d_q) << 22) + (NW'(d_q) << 19)) + NW'(s_q);
	assign dtry = {rem_q[SUMW:0], nlo_q[22]};
	assign dge  = (dtry >= {1'b0, dv_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q <= '0;
			pslot_q <= '0;
			fill_q  <= '0;
			mask_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (add_word)
				mask_q <= commit ? '0 : (mask_q | mask_set);
			if (commit) begin
				wslot_q <= (wslot_q == SLW'(HISTORY - 1)) ? '0 : wslot_q + SLW'(1);
				pslot_q <= (pslot_q == FLW'(HISTORY)) ? '0 : pslot_q + FLW'(1);
				if (fill_q != FLW'(HISTORY))
					fill_q <= fill_q + FLW'(1);
			end
			if (cmd.rq_init)
				found_q <= 1'b0;
			else if (cmd.rq_eval && overlap && !sts.mismatch)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			lo_q  <= in_pos;
			hi_q  <= in_end;
			win_q <= in_win;
		end
		if (cmd.rq_init) begin
			rslot_q <= (fill_q == FLW'(HISTORY)) ? wslot_q : '0;
			i_q     <= '0;
			lim_q   <= fill_q;
			tl_q    <= '0;
			samp_q  <= '0;
			unm_q   <= '0;
		end
		if (cmd.rq_eval && overlap && !sts.mismatch) begin
			if (!found_q) begin
				first_pos_q <= r_pos;
				cc_q        <= r_chans;
			end
			first_rec_q <= !found_q;
		end
		if (cmd.rq_eval || cmd.sq_eval)
			prod_q <= 23'(r_chans) * 23'(r_len);
		if (cmd.rq_acc) begin
			tl_q   <= tl_sum[20] ? 20'hFFFFF : tl_sum[19:0];
			samp_q <= samp_sum[26] ? 26'h3FFFFFF : samp_sum[25:0];
			unm_q  <= unm_sum[26] ? 26'h3FFFFFF : unm_sum[25:0];
			j_q    <= '0;
		end
		if (cmd.ch_wr || cmd.out_ld)
			j_q <= j_q + 7'd1;
		if (cmd.out_init)
			j_q <= '0;
		if (cmd.rec_next) begin
			i_q     <= i_q + FLW'(1);
			rslot_q <= (rslot_q == SLW'(HISTORY - 1)) ? '0 : rslot_q + SLW'(1);
		end
		// stats walk runs newest first
		if (cmd.sq_init) begin
			rslot_q <= (wslot_q == '0) ? SLW'(HISTORY - 1) : wslot_q - SLW'(1);
			i_q     <= '0;
			lim_q   <= win_lim;
			s_q     <= '0;
			u_q     <= '0;
		end
		if (cmd.sq_eval)
			u_q <= u_q + SUMW'(r_unm);
		if (cmd.sq_acc) begin
			s_q     <= s_q + SUMW'(prod_q);
			i_q     <= i_q + FLW'(1);
			rslot_q <= (rslot_q == '0) ? SLW'(HISTORY - 1) : rslot_q - SLW'(1);
		end
		if (cmd.div_init) begin
			dz_q <= (u_q >= s_q);
			d_q  <= s_q - u_q;
		end
		if (cmd.div_prep) begin
			rem_q  <= num[NW-1:23];
			nlo_q  <= num[22:0];
			dv_q   <= {s_q, 1'b0};
			quo_q  <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= dge ? (dtry - {1'b0, dv_q}) : dtry;
			nlo_q  <= {nlo_q[21:0], 1'b0};
			quo_q  <= {quo_q[21:0], dge};
			step_q <= step_q + 5'd1;
		end
	end

	// output register
	logic [47:0] o_first_q;
	logic [19:0] o_tl_q, o_chu_q;
	logic [6:0]  o_cc_q;
	logic [25:0] o_samp_q, o_unm_q;
	logic [5:0]  o_chan_q;
	logic [PCT_W-1:0] o_pct_q;
	logic [1:0]  o_kind_q;
	logic        o_last_q, o_valid_q;
	logic        ld_any;
	assign ld_any = cmd.out_ld || cmd.ld_nf || cmd.ld_err || cmd.ld_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_valid_q <= 1'b0;
		else if (ld_any)
			o_valid_q <= 1'b1;
		else if (m_tready)
			o_valid_q <= 1'b0;
	end

	// fields that do not belong to the result kind load as zero
	always_ff @(posedge clk) begin
		if (ld_any) begin
			o_first_q <= cmd.out_ld ? first_pos_q : '0;
			o_tl_q    <= cmd.out_ld ? tl_q : '0;
			o_cc_q    <= cmd.out_ld ? cc_q : '0;
			o_samp_q  <= cmd.out_ld ? samp_q : '0;
			o_unm_q   <= cmd.out_ld ? unm_q : '0;
			o_chan_q  <= cmd.out_ld ? 6'(j_q) : '0;
			o_chu_q   <= (cmd.out_ld && !sts.cc_zero) ? acc_rdata : '0;
			o_pct_q   <= (cmd.ld_st && !dz_q) ? quo_q : '0;
			o_last_q  <= cmd.out_ld ? (sts.cc_zero || sts.j_last) : 1'b1;
			o_kind_q  <= cmd.out_ld ? KIND_SUM :
				cmd.ld_err ? KIND_ERR :
				cmd.ld_st ? KIND_STATS : KIND_NONE;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {o_pct_q, o_chu_q, o_chan_q, o_unm_q, o_samp_q, o_cc_q, o_tl_q,
		o_first_q};

endmodule

// ----- rtl/core/mask_history_stats_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_history_stats_ring
// Ring of recent mask records with range sum and masked-percentage queries.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  s_*      in   add word (op 0), range query (op 1), stats query (op 2)
//  m_*      out  summed channel words, not-found, mismatch or stats result
//
//  Add words are taken back to back; the last word commits the record.
//  Range query: walks every record, reading and accumulating the channel
//  words of each overlapping one, then sends one result word per channel.
//  Stats query: walks each record in the window, then runs the
//  bit-serial divider (23 quotient bits) and loads the result.
//  No request is taken while a query runs.
//  Reset clears the write slot, fill level, staging, found flag, output valid and state; no clearing pass.
//  A stalled result holds in the output register and stalls the walk.
// ----------------------------------------------------------------------------
module mask_history_stats_ring
	import mhs_pkg::*;
#(
	parameter int HISTORY   = 16,
	parameter int MAX_CHANS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// start_pos, end_pos, time_len, chan_count, unmasked_total, chan_index,
	// chan_unmasked, window_chunks, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,  // op
	input  logic                  s_tlast,  // is_last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// first_pos, sum_time_len, sum_chan_count, sum_samples, sum_unmasked,
	// out_chan, out_chan_unmasked, pct_masked
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,  // kind
	output logic                  m_tlast   // last_out
);

	mhs_cmd_t cmd;
	mhs_sts_t sts;

	mhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhs_dp #(.HISTORY(HISTORY), .MAX_CHANS(MAX_CHANS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

	// a query request makes the block busy on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_RANGE || s_tuser == OP_STATS)
		|=> !s_tready)
		else $error("query accepted but block still ready");

	// single-word results always close their request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_ERR || m_tuser == KIND_STATS)
		|-> m_tlast)
		else $error("single result without last");

	// stats result carries nothing but the percentage
	a_stats_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STATS |-> m_tdata[152:0] == '0)
		else $error("stats result has stray fields");

endmodule
